// ===== rtl/core/ssw_pkg.sv =====
// Package for the servo sync-write framer: bus constants, slot codes and the
// item record passed from the framing stage to the byte emitter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ssw_pkg;

  localparam int SERVO_COUNT = 18;
  localparam logic [7:0] SYNC_WRITE_OPCODE = 8'd131;

  localparam logic [7:0] HEADER_BYTE = 8'hFF;
  localparam logic [7:0] BROADCAST_ID = 8'hFE;
  localparam logic [7:0] VALUE_BYTES = 8'd2;
  localparam logic [7:0] START_ADDRESS_RESET = 8'd30;
  localparam logic [7:0] PACKET_LENGTH = 8'((4 + 3 * SERVO_COUNT) % 256);
  localparam logic [7:0] CHECKSUM_BASE = 8'hFF;

  // Sum of the fixed header bytes that enter the checksum (start address excluded)
  localparam logic [7:0] HEADER_SUM = 8'((int'(BROADCAST_ID) + int'(PACKET_LENGTH)
                                          + int'(SYNC_WRITE_OPCODE) + int'(VALUE_BYTES)) % 256);

  // Byte slot within one item's output run
  typedef enum logic [10:0] {
    SLOT_HDR0   = 11'b000_0000_0001,
    SLOT_HDR1   = 11'b000_0000_0010,
    SLOT_BCAST  = 11'b000_0000_0100,
    SLOT_LEN    = 11'b000_0000_1000,
    SLOT_INSTR  = 11'b000_0001_0000,
    SLOT_ADDR   = 11'b000_0010_0000,
    SLOT_SIZE   = 11'b000_0100_0000,
    SLOT_ID     = 11'b000_1000_0000,
    SLOT_LO     = 11'b001_0000_0000,
    SLOT_HI     = 11'b010_0000_0000,
    SLOT_CKSUM  = 11'b100_0000_0000
  } slot_t;

  typedef struct packed {
    logic       first;
    logic       closes;
    logic [6:0] id;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] addr;
    logic [7:0] cksum;
  } item_t;

endpackage

`default_nettype wire

// ===== rtl/core/ssw_channels.sv =====
// Valid/ready channel interfaces for the sync-write framer: servo values in,
// bus bytes out. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ssw_item_if;
  logic        valid;
  logic        ready;
  logic [15:0] servo_value;

  modport source (output valid, output servo_value, input ready);
  modport sink (input valid, input servo_value, output ready);
endinterface

interface ssw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       run_last;
  logic       packet_end;

  modport source (output valid, output tx_byte, output run_last, output packet_end,
                  input ready);
  modport sink (input valid, input tx_byte, input run_last, input packet_end,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ssw_frame.sv =====
// Framing stage: tracks the servo index and running byte sum, holds the start
// address register, and builds one item record per input transfer. Uses ssw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssw_frame
  import ssw_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_write_en,
  input  wire logic  [7:0] cfg_write_data,
  ssw_item_if.sink   item_in,
  input  wire logic  item_ready,
  output      logic  item_load,
  output      item_t item
);

  logic [6:0] servo_index;
  logic [7:0] running_sum;
  logic [7:0] start_address;

  logic       first;
  logic [6:0] id;
  logic       closes;
  logic [7:0] base_sum;
  logic [7:0] sum_next;

  assign item_in.ready = item_ready;
  assign item_load     = item_in.valid && item_ready;

  always_comb begin
    first    = (servo_index == 7'd0);
    id       = servo_index + 7'd1;
    closes   = (id >= 7'(SERVO_COUNT));
    base_sum = first ? (HEADER_SUM + start_address) : running_sum;
    sum_next = base_sum + {1'b0, id} + item_in.servo_value[7:0]
               + item_in.servo_value[15:8];

    item.first  = first;
    item.closes = closes;
    item.id     = id;
    item.lo     = item_in.servo_value[7:0];
    item.hi     = item_in.servo_value[15:8];
    item.addr   = start_address;
    item.cksum  = CHECKSUM_BASE - sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      servo_index   <= '0;
      running_sum   <= '0;
      start_address <= START_ADDRESS_RESET;
    end else begin
      if (cfg_write_en) begin
        start_address <= cfg_write_data;
      end
      if (item_load) begin
        // wrap to a fresh packet after the last servo
        servo_index <= closes ? 7'd0 : id;
        running_sum <= closes ? 8'd0 : sum_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ssw_emit.sv =====
// Byte emitter: holds one item record and walks its byte slots into a
// registered output, one byte per cycle while the sink is ready. Uses ssw_pkg and ssw_byte_if.
`timescale 1ns / 1ps
`default_nettype none

module ssw_emit
  import ssw_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  item_load,
  input  wire item_t item,
  output      logic  item_ready,
  ssw_byte_if.source byte_out
);

  item_t      held;
  logic       held_valid;
  slot_t      slot;
  slot_t      slot_next;

  logic [7:0] cur_byte;
  logic       is_last;
  logic       adv;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_end;

  always_comb begin
    unique case (slot)
      SLOT_HDR0:  cur_byte = HEADER_BYTE;
      SLOT_HDR1:  cur_byte = HEADER_BYTE;
      SLOT_BCAST: cur_byte = BROADCAST_ID;
      SLOT_LEN:   cur_byte = PACKET_LENGTH;
      SLOT_INSTR: cur_byte = SYNC_WRITE_OPCODE;
      SLOT_ADDR:  cur_byte = held.addr;
      SLOT_SIZE:  cur_byte = VALUE_BYTES;
      SLOT_ID:    cur_byte = {1'b0, held.id};
      SLOT_LO:    cur_byte = held.lo;
      SLOT_HI:    cur_byte = held.hi;
      SLOT_CKSUM: cur_byte = held.cksum;
      default:    cur_byte = '0;
    endcase

    unique case (slot)
      SLOT_HDR0:  slot_next = SLOT_HDR1;
      SLOT_HDR1:  slot_next = SLOT_BCAST;
      SLOT_BCAST: slot_next = SLOT_LEN;
      SLOT_LEN:   slot_next = SLOT_INSTR;
      SLOT_INSTR: slot_next = SLOT_ADDR;
      SLOT_ADDR:  slot_next = SLOT_SIZE;
      SLOT_SIZE:  slot_next = SLOT_ID;
      SLOT_ID:    slot_next = SLOT_LO;
      SLOT_LO:    slot_next = SLOT_HI;
      SLOT_HI:    slot_next = SLOT_CKSUM;
      default:    slot_next = SLOT_HDR0;
    endcase

    is_last    = held.closes ? (slot == SLOT_CKSUM) : (slot == SLOT_HI);
    adv        = held_valid && (!out_valid || byte_out.ready);
    // free the holding register on the item's final byte
    item_ready = !held_valid || (adv && is_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      slot       <= SLOT_HDR0;
    end else if (item_load) begin
      held_valid <= 1'b1;
      slot       <= item.first ? SLOT_HDR0 : SLOT_ID;
    end else if (adv && is_last) begin
      held_valid <= 1'b0;
    end else if (adv) begin
      slot <= slot_next;
    end
  end

  always_ff @(posedge clk) begin
    if (item_load) begin
      held <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (byte_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte <= cur_byte;
      out_last <= is_last;
      out_end  <= (slot == SLOT_CKSUM);
    end
  end

  assign byte_out.valid      = out_valid;
  assign byte_out.tx_byte    = out_byte;
  assign byte_out.run_last   = out_last;
  assign byte_out.packet_end = out_end;

endmodule

`default_nettype wire

// ===== rtl/core/servo_sync_write_framer_core.sv =====
// Servo bus sync-write framer, top level: one 16-bit value per servo in id
// order becomes a broadcast sync-write packet. Uses ssw_pkg, ssw_channels,
// ssw_frame and ssw_emit.
//
// One byte leaves per cycle through a registered output while the sink is
// ready, so an item is 3 bytes (id, low, high), 10 when it opens a packet
// (seven header bytes first) and one more when it closes the packet with the
// checksum; the byte emitter's slot walk sets that order. The next item is taken
// during the current item's final byte, so back-to-back items stream without gaps.
// The start address is sampled by the first item of each packet.
`timescale 1ns / 1ps
`default_nettype none

module servo_sync_write_framer_core
  import ssw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_write_en,
  input  wire logic [7:0] cfg_write_data,
  ssw_item_if.sink  item_in,
  ssw_byte_if.source byte_out
);

  logic  item_load;
  logic  item_ready;
  item_t item;

  ssw_frame u_frame (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .item_in        (item_in),
    .item_ready     (item_ready),
    .item_load      (item_load),
    .item           (item)
  );

  ssw_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .item_load  (item_load),
    .item       (item),
    .item_ready (item_ready),
    .byte_out   (byte_out)
  );

endmodule

`default_nettype wire
